// ===== sv/tms_pkg.sv =====
`timescale 1ns / 1ps

package tms_pkg;

  // pipeline depths
  localparam int unsigned SC_LAT  = 23;
  localparam int unsigned MX_LAT  = 4;
  localparam int unsigned TOT_LAT = SC_LAT + MX_LAT;

  // angle reduction constants: 90 degrees is 45 * 2^17 in Q16.16
  localparam logic [16:0] U_OFFSET    = 17'd16560;  // 368 * 45, keeps quadrant phase
  localparam logic [15:0] RECIP45     = 16'd46603;  // floor(2^21 / 45)
  localparam logic [5:0]  DIV45       = 6'd45;
  localparam logic [26:0] RAD_PER_DEG = 27'd74961321;

  localparam logic signed [31:0] ONE_Q30 = 32'sh4000_0000;

  typedef struct packed {
    logic signed [31:0] translate_x;
    logic signed [31:0] translate_y;
    logic signed [31:0] translate_z;
    logic signed [31:0] angle_x_deg;
    logic signed [31:0] angle_y_deg;
    logic signed [31:0] angle_z_deg;
    logic signed [31:0] scale_x;
    logic signed [31:0] scale_y;
    logic signed [31:0] scale_z;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] m00;
    logic signed [31:0] m01;
    logic signed [31:0] m02;
    logic signed [31:0] m10;
    logic signed [31:0] m11;
    logic signed [31:0] m12;
    logic signed [31:0] m20;
    logic signed [31:0] m21;
    logic signed [31:0] m22;
    logic signed [31:0] m03;
    logic signed [31:0] m13;
    logic signed [31:0] m23;
  } out_word_t;

  // one lane of a taylor series in flight
  typedef struct packed {
    logic [31:0]        t;
    logic signed [33:0] sum;
    logic [31:0]        x2;
  } lane_t;

  // sine and cosine of the three angles
  typedef struct packed {
    logic signed [31:0] sx;
    logic signed [31:0] cx;
    logic signed [31:0] sy;
    logic signed [31:0] cy;
    logic signed [31:0] sz;
    logic signed [31:0] cz;
  } trig_t;

endpackage

// ===== sv/tms_if.sv =====
`timescale 1ns / 1ps

interface tms_in_if;
  logic               valid;
  logic               ready;
  tms_pkg::in_word_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface tms_out_if;
  logic               valid;
  logic               ready;
  tms_pkg::out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/trs_model_matrix_builder.sv =====
`timescale 1ns / 1ps

// Builds the model matrix T * Rx * Ry * Rz * S for one object per word, all values
// signed Q16.16, the rotation-scale block saturated and the translation column copied.
// A new word is taken every clock cycle unless stalled; each result passes through the
// sine/cosine pipeline (three stages per series term, six cosine terms) and then
// four matrix stages. The whole pipeline stalls only while a finished result is
// held at the output and not taken; empty slots still let words in.
module trs_model_matrix_builder (
  input  logic      clk_i,
  input  logic      rst_ni,
  tms_in_if.sink    in_i,
  tms_out_if.source out_o
);

  localparam int unsigned SC_LAT  = tms_pkg::SC_LAT;
  localparam int unsigned TOT_LAT = tms_pkg::TOT_LAT;

  logic en;
  logic [TOT_LAT-1:0] vld_q;
  tms_pkg::in_word_t side_sh_q [SC_LAT];
  tms_pkg::trig_t trig;
  tms_pkg::out_word_t mat;

  // global advance
  assign en         = !vld_q[TOT_LAT-1] || out_o.ready;
  assign in_i.ready = en;

  // valid bits alongside the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[TOT_LAT-2:0], in_i.valid};
    end
  end

  // translation and scale wait for the trig results
  always_ff @(posedge clk_i) begin
    if (en) begin
      side_sh_q[0] <= in_i.data;
      for (int i = 1; i < SC_LAT; i++) begin
        side_sh_q[i] <= side_sh_q[i-1];
      end
    end
  end

  tms_sincos u_sc_x (
    .clk_i   (clk_i),
    .en_i    (en),
    .angle_i (in_i.data.angle_x_deg),
    .sin_o   (trig.sx),
    .cos_o   (trig.cx)
  );

  tms_sincos u_sc_y (
    .clk_i   (clk_i),
    .en_i    (en),
    .angle_i (in_i.data.angle_y_deg),
    .sin_o   (trig.sy),
    .cos_o   (trig.cy)
  );

  tms_sincos u_sc_z (
    .clk_i   (clk_i),
    .en_i    (en),
    .angle_i (in_i.data.angle_z_deg),
    .sin_o   (trig.sz),
    .cos_o   (trig.cz)
  );

  tms_matrix u_matrix (
    .clk_i  (clk_i),
    .en_i   (en),
    .trig_i (trig),
    .side_i (side_sh_q[SC_LAT-1]),
    .mat_o  (mat)
  );

  assign out_o.valid = vld_q[TOT_LAT-1];
  assign out_o.data  = mat;

  // a stall freezes every slot
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld_q))
    else $error("pipeline moved during stall");

  // an accepted word occupies the first slot
  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> vld_q[0])
    else $error("accepted word lost at entry");

  // the y sine and z cosine results stay within unit range
  a_trig_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[SC_LAT-1] |-> (trig.sy <= tms_pkg::ONE_Q30 && trig.sy >= -tms_pkg::ONE_Q30
                         && trig.cz <= tms_pkg::ONE_Q30 && trig.cz >= -tms_pkg::ONE_Q30))
    else $error("sine or cosine out of range");

endmodule

// ===== sv/tms_term.sv =====
`timescale 1ns / 1ps

// one series term: t = ((t * x2) >> 30) / DIV, then sum -/+= t
module tms_term #(
  parameter int unsigned DIV = 6,
  parameter bit          SUB = 1'b1
) (
  input  logic           clk_i,
  input  logic           en_i,
  input  tms_pkg::lane_t lane_i,
  output tms_pkg::lane_t lane_o
);

  localparam int unsigned SH    = 33 + $clog2(DIV + 1) - 1;
  localparam logic [33:0] RECIP = 34'((67'd1 << SH) / DIV);

  tms_pkg::lane_t a_q, b_q, c_q;
  logic [63:0] prod_a;
  logic [32:0] v_d, v_q, v_b_q;
  logic [66:0] m_d, m_q;
  logic [32:0] qe, q;
  logic [35:0] rem;

  // stage a: multiply by x squared
  assign prod_a = 64'(lane_i.t) * 64'(lane_i.x2);
  assign v_d    = prod_a[62:30];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_q <= lane_i;
      v_q <= v_d;
    end
  end

  // stage b: reciprocal multiply
  assign m_d = 67'(v_q) * 67'(RECIP);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      b_q   <= a_q;
      v_b_q <= v_q;
      m_q   <= m_d;
    end
  end

  // stage c: quotient correction and accumulate
  always_comb begin
    qe  = 33'(m_q >> SH);
    rem = 36'(v_b_q) - 36'(qe) * 36'(DIV);
    q   = (rem >= 36'(DIV)) ? qe + 33'd1 : qe;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c_q.x2 <= b_q.x2;
      c_q.t  <= q[31:0];
      if (SUB) begin
        c_q.sum <= b_q.sum - $signed({2'b00, q[31:0]});
      end else begin
        c_q.sum <= b_q.sum + $signed({2'b00, q[31:0]});
      end
    end
  end

  assign lane_o = c_q;

endmodule

// ===== sv/tms_sincos.sv =====
`timescale 1ns / 1ps

// sine and cosine of a Q16.16 angle in degrees, Q2.30 results
module tms_sincos (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic signed [31:0] angle_i,
  output logic signed [31:0] sin_o,
  output logic signed [31:0] cos_o
);

  localparam int unsigned QD_DEPTH = 18;

  logic [16:0] u_d, u_q, l_q;
  logic [32:0] pr_d, pr_q;
  logic [10:0] qe, qc;
  logic [16:0] rem, remc;
  logic [22:0] f_q;
  logic [1:0]  quad2_q, quad3_q, quad4_q;
  logic [1:0]  quad_sh_q [QD_DEPTH];
  logic [49:0] xp;
  logic [30:0] x_q;
  logic [61:0] x2p;
  tms_pkg::lane_t sin_seed_q, cos_seed_q;
  tms_pkg::lane_t sin_l [6];
  tms_pkg::lane_t cos_l [7];
  logic signed [33:0] sin_dly_q [3];
  logic signed [31:0] sv, cv;
  logic signed [31:0] sin_q, cos_q;

  // stage 1: split at 2^17 and start the divide by 45
  assign u_d  = 17'({{2{angle_i[31]}}, angle_i[31:17]}) + tms_pkg::U_OFFSET;
  assign pr_d = 33'(u_d) * 33'(tms_pkg::RECIP45);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      u_q  <= u_d;
      l_q  <= angle_i[16:0];
      pr_q <= pr_d;
    end
  end

  // stage 2: quotient fix, quadrant and remainder within 90 degrees
  always_comb begin
    qe  = pr_q[31:21];
    rem = u_q - 17'(qe) * 17'(tms_pkg::DIV45);
    if (rem >= 17'(tms_pkg::DIV45)) begin
      remc = rem - 17'(tms_pkg::DIV45);
      qc   = qe + 11'd1;
    end else begin
      remc = rem;
      qc   = qe;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      f_q     <= {remc[5:0], l_q};
      quad2_q <= qc[1:0];
    end
  end

  // stage 3: degrees to radians
  assign xp = 50'(f_q) * 50'(tms_pkg::RAD_PER_DEG);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q     <= xp[48:18];
      quad3_q <= quad2_q;
    end
  end

  // stage 4: x squared, seed both series
  assign x2p = 62'(x_q) * 62'(x_q);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sin_seed_q.t   <= 32'(x_q);
      sin_seed_q.sum <= 34'(x_q);
      sin_seed_q.x2  <= x2p[61:30];
      cos_seed_q.t   <= 32'(tms_pkg::ONE_Q30);
      cos_seed_q.sum <= 34'(tms_pkg::ONE_Q30);
      cos_seed_q.x2  <= x2p[61:30];
      quad4_q        <= quad3_q;
    end
  end

  assign sin_l[0] = sin_seed_q;
  assign cos_l[0] = cos_seed_q;

  // series terms
  for (genvar k = 1; k <= 5; k++) begin : g_sin
    tms_term #(.DIV((2 * k) * (2 * k + 1)), .SUB(k % 2 == 1)) u_term (
      .clk_i  (clk_i),
      .en_i   (en_i),
      .lane_i (sin_l[k-1]),
      .lane_o (sin_l[k])
    );
  end

  for (genvar k = 1; k <= 6; k++) begin : g_cos
    tms_term #(.DIV((2 * k - 1) * (2 * k)), .SUB(k % 2 == 1)) u_term (
      .clk_i  (clk_i),
      .en_i   (en_i),
      .lane_i (cos_l[k-1]),
      .lane_o (cos_l[k])
    );
  end

  // align sine with the longer cosine series, carry the quadrant
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sin_dly_q[0] <= sin_l[5].sum;
      sin_dly_q[1] <= sin_dly_q[0];
      sin_dly_q[2] <= sin_dly_q[1];
      quad_sh_q[0] <= quad4_q;
      for (int i = 1; i < QD_DEPTH; i++) begin
        quad_sh_q[i] <= quad_sh_q[i-1];
      end
    end
  end

  // clamp to [0, 1] and unfold the quadrant
  always_comb begin
    if (sin_dly_q[2] < 34'sd0) begin
      sv = 32'sd0;
    end else if (sin_dly_q[2] > 34'(tms_pkg::ONE_Q30)) begin
      sv = tms_pkg::ONE_Q30;
    end else begin
      sv = sin_dly_q[2][31:0];
    end
    if (cos_l[6].sum < 34'sd0) begin
      cv = 32'sd0;
    end else if (cos_l[6].sum > 34'(tms_pkg::ONE_Q30)) begin
      cv = tms_pkg::ONE_Q30;
    end else begin
      cv = cos_l[6].sum[31:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      case (quad_sh_q[QD_DEPTH-1])
        2'd0: begin
          sin_q <= sv;
          cos_q <= cv;
        end
        2'd1: begin
          sin_q <= cv;
          cos_q <= -sv;
        end
        2'd2: begin
          sin_q <= -sv;
          cos_q <= -cv;
        end
        default: begin
          sin_q <= -cv;
          cos_q <= sv;
        end
      endcase
    end
  end

  assign sin_o = sin_q;
  assign cos_o = cos_q;

endmodule

// ===== sv/tms_matrix.sv =====
`timescale 1ns / 1ps

// rotation products, scale and saturation, four stages
module tms_matrix (
  input  logic                clk_i,
  input  logic                en_i,
  input  tms_pkg::trig_t      trig_i,
  input  tms_pkg::in_word_t   side_i,
  output tms_pkg::out_word_t  mat_o
);

  // q2.30 product rounded half up
  function automatic logic signed [31:0] mul30(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
    logic signed [63:0] p;
    p = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
    p = p + 64'sd536870912;
    mul30 = 32'(p >>> 30);
  endfunction

  tms_pkg::in_word_t side1_q, side2_q, side3_q;
  logic signed [31:0] sxsy_q, cxsy_q, cycz_q, cysz_q, cxsz_q, cxcz_q;
  logic signed [31:0] sxsz_q, sxcz_q, sxcy_q, cxcy_q, cz_q, sz_q, sy_q;
  logic signed [32:0] rot_q [9];
  logic signed [64:0] prd_q [9];
  logic signed [31:0] scl [3];
  logic signed [31:0] elem [9];
  tms_pkg::out_word_t mat_q;

  // stage 1: pair products
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side1_q <= side_i;
      sxsy_q  <= mul30(trig_i.sx, trig_i.sy);
      cxsy_q  <= mul30(trig_i.cx, trig_i.sy);
      cycz_q  <= mul30(trig_i.cy, trig_i.cz);
      cysz_q  <= mul30(trig_i.cy, trig_i.sz);
      cxsz_q  <= mul30(trig_i.cx, trig_i.sz);
      cxcz_q  <= mul30(trig_i.cx, trig_i.cz);
      sxsz_q  <= mul30(trig_i.sx, trig_i.sz);
      sxcz_q  <= mul30(trig_i.sx, trig_i.cz);
      sxcy_q  <= mul30(trig_i.sx, trig_i.cy);
      cxcy_q  <= mul30(trig_i.cx, trig_i.cy);
      cz_q    <= trig_i.cz;
      sz_q    <= trig_i.sz;
      sy_q    <= trig_i.sy;
    end
  end

  // stage 2: rotation entries
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side2_q  <= side1_q;
      rot_q[0] <= 33'(cycz_q);
      rot_q[1] <= -33'(cysz_q);
      rot_q[2] <= 33'(sy_q);
      rot_q[3] <= 33'(mul30(sxsy_q, cz_q)) + 33'(cxsz_q);
      rot_q[4] <= 33'(cxcz_q) - 33'(mul30(sxsy_q, sz_q));
      rot_q[5] <= -33'(sxcy_q);
      rot_q[6] <= 33'(sxsz_q) - 33'(mul30(cxsy_q, cz_q));
      rot_q[7] <= 33'(mul30(cxsy_q, sz_q)) + 33'(sxcz_q);
      rot_q[8] <= 33'(cxcy_q);
    end
  end

  // stage 3: scale by column
  assign scl[0] = side2_q.scale_x;
  assign scl[1] = side2_q.scale_y;
  assign scl[2] = side2_q.scale_z;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side3_q <= side2_q;
      for (int i = 0; i < 9; i++) begin
        prd_q[i] <= $signed({{32{rot_q[i][32]}}, rot_q[i]})
                    * $signed({{33{scl[i%3][31]}}, scl[i%3]});
      end
    end
  end

  // stage 4: round and saturate
  always_comb begin
    logic signed [65:0] r;
    logic signed [35:0] v;
    for (int i = 0; i < 9; i++) begin
      r = 66'(prd_q[i]) + 66'sd536870912;
      v = 36'(r >>> 30);
      if (v > 36'sd2147483647) begin
        elem[i] = 32'sh7fff_ffff;
      end else if (v < -36'sd2147483648) begin
        elem[i] = 32'sh8000_0000;
      end else begin
        elem[i] = v[31:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mat_q.m00 <= elem[0];
      mat_q.m01 <= elem[1];
      mat_q.m02 <= elem[2];
      mat_q.m10 <= elem[3];
      mat_q.m11 <= elem[4];
      mat_q.m12 <= elem[5];
      mat_q.m20 <= elem[6];
      mat_q.m21 <= elem[7];
      mat_q.m22 <= elem[8];
      mat_q.m03 <= side3_q.translate_x;
      mat_q.m13 <= side3_q.translate_y;
      mat_q.m23 <= side3_q.translate_z;
    end
  end

  assign mat_o = mat_q;

endmodule

// ===== sim/tms_matrix_checker.sv =====
`timescale 1ns / 1ps

module tms_matrix_checker (
  input  logic clk_i,
  input  logic rst_ni,
  tms_in_if    in_w,
  tms_out_if   out_w,
  output int   errors_o,
  output int   pending_o
);

  localparam longint DEG360_Q16 = longint'(360) << 16;
  localparam longint DEG90_Q16  = longint'(90) << 16;
  localparam longint UNIT_Q30   = longint'(1) << 30;
  localparam longint RAD_Q32    = 74961321;

  tms_pkg::out_word_t expected_matrices[$];
  int                 error_count;

  assign errors_o  = error_count;
  assign pending_o = expected_matrices.size();

  // q2.30 product rounded half up
  function automatic longint mul_q30(longint a, longint b);
    return (a * b + (longint'(1) << 29)) >>> 30;
  endfunction

  // sine and cosine of a q16.16 angle in degrees, both q2.30
  function automatic void angle_sin_cos(input logic signed [31:0] angle,
                                        output longint s, output longint c);
    longint            r, quad, frac, sv, cv;
    longint unsigned   x, x2, t;
    r = longint'(angle) % DEG360_Q16;
    if (r < 0) r += DEG360_Q16;
    quad = r / DEG90_Q16;
    frac = r % DEG90_Q16;
    x  = (longint'(frac) * RAD_Q32) >> 18;
    x2 = (x * x) >> 30;
    // sine series
    t  = x;
    sv = longint'(x);
    for (int k = 1; k <= 5; k++) begin
      t = ((t * x2) >> 30) / longint'((2 * k) * (2 * k + 1));
      if (k & 1) sv -= longint'(t);
      else sv += longint'(t);
    end
    // cosine series
    t  = UNIT_Q30;
    cv = UNIT_Q30;
    for (int k = 1; k <= 6; k++) begin
      t = ((t * x2) >> 30) / longint'((2 * k - 1) * (2 * k));
      if (k & 1) cv -= longint'(t);
      else cv += longint'(t);
    end
    if (sv < 0) sv = 0;
    if (sv > UNIT_Q30) sv = UNIT_Q30;
    if (cv < 0) cv = 0;
    if (cv > UNIT_Q30) cv = UNIT_Q30;
    // quadrant fold
    case (quad)
      0: begin s = sv;  c = cv;  end
      1: begin s = cv;  c = -sv; end
      2: begin s = -sv; c = -cv; end
      default: begin s = -cv; c = sv; end
    endcase
  endfunction

  // rotation entry times column scale, saturated to 32 bits
  function automatic logic signed [31:0] scaled_entry(longint rot,
                                                      logic signed [31:0] scl);
    longint v;
    v = (rot * longint'(scl) + (longint'(1) << 29)) >>> 30;
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v[31:0];
  endfunction

  function automatic tms_pkg::out_word_t build_matrix(tms_pkg::in_word_t w);
    longint             sx, cx, sy, cy, sz, cz, sxsy, cxsy;
    longint             rot[9];
    tms_pkg::out_word_t m;
    angle_sin_cos(w.angle_x_deg, sx, cx);
    angle_sin_cos(w.angle_y_deg, sy, cy);
    angle_sin_cos(w.angle_z_deg, sz, cz);
    sxsy = mul_q30(sx, sy);
    cxsy = mul_q30(cx, sy);
    rot[0] = mul_q30(cy, cz);
    rot[1] = -mul_q30(cy, sz);
    rot[2] = sy;
    rot[3] = mul_q30(sxsy, cz) + mul_q30(cx, sz);
    rot[4] = mul_q30(cx, cz) - mul_q30(sxsy, sz);
    rot[5] = -mul_q30(sx, cy);
    rot[6] = mul_q30(sx, sz) - mul_q30(cxsy, cz);
    rot[7] = mul_q30(cxsy, sz) + mul_q30(sx, cz);
    rot[8] = mul_q30(cx, cy);
    m.m00 = scaled_entry(rot[0], w.scale_x);
    m.m01 = scaled_entry(rot[1], w.scale_y);
    m.m02 = scaled_entry(rot[2], w.scale_z);
    m.m10 = scaled_entry(rot[3], w.scale_x);
    m.m11 = scaled_entry(rot[4], w.scale_y);
    m.m12 = scaled_entry(rot[5], w.scale_z);
    m.m20 = scaled_entry(rot[6], w.scale_x);
    m.m21 = scaled_entry(rot[7], w.scale_y);
    m.m22 = scaled_entry(rot[8], w.scale_z);
    m.m03 = w.translate_x;
    m.m13 = w.translate_y;
    m.m23 = w.translate_z;
    return m;
  endfunction

  string elem_names[12] = '{"m00", "m01", "m02", "m10", "m11", "m12",
                            "m20", "m21", "m22", "m03", "m13", "m23"};

  // watch both channels, predict on input words, compare on output words
  always @(posedge clk_i or negedge rst_ni) begin
    tms_pkg::out_word_t want, got;
    if (!rst_ni) begin
      error_count = 0;
      expected_matrices.delete();
    end else begin
      if (in_w.valid && in_w.ready) expected_matrices.push_back(build_matrix(in_w.data));
      if (out_w.valid && out_w.ready) begin
        got = out_w.data;
        if (expected_matrices.size() == 0) begin
          error_count++;
          $display("%0t: unexpected output word %h", $time, got);
        end else begin
          want = expected_matrices.pop_front();
          for (int i = 0; i < 12; i++) begin
            if (want[383 - 32 * i -: 32] !== got[383 - 32 * i -: 32]) begin
              error_count++;
              $display("%0t: %s expected %h actual %h", $time, elem_names[i],
                       want[383 - 32 * i -: 32], got[383 - 32 * i -: 32]);
            end
          end
        end
      end
    end
  end

endmodule

// ===== sim/trs_model_matrix_builder_test.sv =====
`timescale 1ns / 1ps

module trs_model_matrix_builder_test;

  localparam logic signed [31:0] Q_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] Q_ONE = 32'sh0001_0000;

  logic clk_i;
  logic rst_ni;
  bit   calm;
  int   errors, pending;

  tms_in_if  in_w ();
  tms_out_if out_w ();

  trs_model_matrix_builder dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_w),
    .out_o  (out_w)
  );

  tms_matrix_checker checker_u (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_w      (in_w),
    .out_w     (out_w),
    .errors_o  (errors),
    .pending_o (pending)
  );

  // clock
  always begin
    clk_i = 1'b1; #5;
    clk_i = 1'b0; #5;
  end

  // run limit
  initial begin
    #5ms;
    $display("FAIL");
    $finish;
  end

  function automatic int draw_gap();
    return calm ? 0 : $urandom_range(0, 14);
  endfunction

  function automatic logic signed [31:0] deg(int d);
    return d <<< 16;
  endfunction

  // angle: full range, quadrant edges, or within 384 degrees of zero
  function automatic logic signed [31:0] rand_angle();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return deg(90 * ($urandom_range(0, 16) - 8)) + ($urandom_range(0, 6) - 3);
      2: return $urandom_range(0, 32'h0300_0000) - 32'h0180_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic signed [31:0] rand_scale();
    case ($urandom_range(0, 5))
      0: return 0;
      1: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
      2: return $urandom_range(0, 1) ? Q_MAX : Q_MIN;
      3: return $urandom_range(0, 1) ? Q_ONE : -Q_ONE;
      default: return $urandom;
    endcase
  endfunction

  function automatic tms_pkg::in_word_t make_word(
      logic signed [31:0] ax, logic signed [31:0] ay,
      logic signed [31:0] az, logic signed [31:0] sx,
      logic signed [31:0] sy, logic signed [31:0] sz);
    tms_pkg::in_word_t w;
    w.translate_x = $urandom;
    w.translate_y = $urandom;
    w.translate_z = $urandom;
    w.angle_x_deg = ax;
    w.angle_y_deg = ay;
    w.angle_z_deg = az;
    w.scale_x     = sx;
    w.scale_y     = sy;
    w.scale_z     = sz;
    return w;
  endfunction

  // offer one word after a random gap, hold until taken
  task automatic send_word(tms_pkg::in_word_t w);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_w.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_w.valid <= 1'b1;
    in_w.data  <= w;
    do @(posedge clk_i); while (!in_w.ready);
  endtask

  // output side: random stall before each word
  initial begin
    int gap;
    out_w.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      gap = draw_gap();
      if (gap > 0) begin
        out_w.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_w.ready <= 1'b1;
      do @(posedge clk_i); while (!out_w.valid);
    end
  end

  // stimulus and verdict
  initial begin
    tms_pkg::in_word_t w;
    in_w.valid = 1'b0;
    in_w.data  = '0;
    calm   = 1'b0;
    rst_ni = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: identity, quadrant angles, extremes, saturation, zero and mirror scale
    send_word(make_word(0, 0, 0, Q_ONE, Q_ONE, Q_ONE));
    send_word(make_word(deg(90), deg(180), deg(270), Q_ONE, Q_ONE, Q_ONE));
    send_word(make_word(deg(360), deg(-90), deg(-180), Q_ONE, Q_ONE, Q_ONE));
    send_word(make_word(deg(-270), deg(-360), deg(720), Q_ONE, Q_ONE, Q_ONE));
    send_word(make_word(deg(45), deg(30), deg(60), Q_ONE, Q_ONE, Q_ONE));
    send_word(make_word(deg(90) - 1, deg(180) - 1, deg(360) - 1, Q_ONE, Q_ONE, Q_ONE));
    send_word(make_word(-1, 1, deg(90) + 1, Q_ONE, Q_ONE, Q_ONE));
    send_word(make_word(Q_MAX, Q_MIN, Q_MAX, Q_ONE, Q_ONE, Q_ONE));
    send_word(make_word(Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MAX, Q_MAX));
    send_word(make_word(0, 0, 0, Q_MAX, Q_MAX, Q_MAX));
    send_word(make_word(0, 0, 0, Q_MIN, Q_MIN, Q_MIN));
    send_word(make_word(deg(180), deg(180), deg(180), Q_MIN, Q_MIN, Q_MIN));
    send_word(make_word(deg(45), deg(45), deg(45), Q_MAX, Q_MIN, Q_MAX));
    send_word(make_word(deg(10), deg(20), deg(30), 0, 0, 0));
    send_word(make_word(deg(10), deg(20), deg(30), -Q_ONE, -Q_ONE, -Q_ONE));
    send_word(make_word(deg(33), deg(-77), deg(123), -3 * Q_ONE, Q_ONE / 2, 7));
    w = make_word(0, 0, 0, Q_ONE, Q_ONE, Q_ONE);
    w.translate_x = Q_MAX; w.translate_y = Q_MIN; w.translate_z = 0;
    send_word(w);
    w.translate_x = Q_MIN; w.translate_y = Q_MAX; w.translate_z = -1;
    send_word(w);

    // random words, with stretches of no idling on either side
    for (int i = 0; i < 700; i++) begin
      if (i % 50 == 0) calm = ($urandom_range(0, 3) == 0);
      send_word(make_word(rand_angle(), rand_angle(), rand_angle(),
                          rand_scale(), rand_scale(), rand_scale()));
    end
    in_w.valid <= 1'b0;

    // drain
    calm = 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (tms_pkg::TOT_LAT + 10) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
